// File: rtl/core/wfbc_pkg.sv
package wfbc_pkg;

    // Controller phases, encoded as they are reported on the result stream.
    typedef enum logic [1:0] {
        PH_BACK = 2'd0,
        PH_FWD  = 2'd1,
        PH_WALL = 2'd2,
        PH_OBST = 2'd3
    } phase_t;

    // Which command, if any, takes the scaled product.
    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_DRIVE = 2'd1,
        SEL_TURN  = 2'd2
    } sel_t;

    // Configuration register indexes (byte address / 4).
    localparam logic [1:0] REG_FOLLOW_SIDE  = 2'd0;
    localparam logic [1:0] REG_GAIN         = 2'd1;
    localparam logic [1:0] REG_HOLD_SECONDS = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd12288;
    localparam logic [7:0]  HOLD_RESET = 8'd2;

    localparam logic signed [8:0] IR_TARGET     = 9'sd100;
    localparam logic signed [8:0] MID_TARGET    = 9'sd127;
    localparam logic signed [8:0] MID_THRESHOLD = 9'sd110;

    localparam logic [5:0] BUMP_NONE = 6'h3F;

    localparam logic signed [15:0] Q_BACK_DRIVE = -16'sd204;
    localparam logic signed [15:0] Q_BACK_TURN  = -16'sd4096;
    localparam logic signed [15:0] Q_HALF       = 16'sd2048;
    localparam logic signed [15:0] Q_OBST_TURN  = -16'sd2867;
    localparam logic signed [15:0] Q_ZERO       = 16'sd0;

    // Unsigned division of a 24-bit product by 100 or 600 as a multiply by
    // ceil(2^k / d) and a right shift by k; exact for every 24-bit operand.
    localparam int PROD_W    = 24;
    localparam int RECIP_W   = 25;
    localparam int FULL_W    = PROD_W + RECIP_W;
    localparam int Q_W       = 17;
    localparam int SHIFT_100 = 31;
    localparam int SHIFT_600 = 34;
    localparam int Q600_W    = FULL_W - SHIFT_600;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
    localparam logic [RECIP_W-1:0] RECIP_600 = 25'd28633116;

    typedef struct packed {
        logic        follow_side;
        logic [15:0] gain;
        logic [7:0]  hold_seconds;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  ir_left;
        logic [7:0]  ir_middle;
        logic [7:0]  ir_right;
        logic [5:0]  bump_switches;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              div600;
        sel_t              sel;
        logic [15:0]       drive_k;
        logic [15:0]       turn_k;
        phase_t            phase;
    } stage1_t;

    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           neg;
        sel_t           sel;
        logic [15:0]    drive_k;
        logic [15:0]    turn_k;
        phase_t         phase;
    } stage2_t;

    typedef struct packed {
        phase_t phase;
        logic   stamp_valid;
    } status_t;

endpackage

// File: rtl/core/wall_follow_bump_controller_unit.sv
// A transfer accepted on the input passes through the registered input stage,
// reciprocal multiply and output stages before its result shows on m_tvalid.
// Throughput: one item per cycle unless m_tready stalls a full pipeline; the
// stages are elastic, so a bubble lets a new item in while a result waits.
// Reset (rst_n low, asynchronous): pipeline empty, phase wall follow, no time
// stamp held, follow_side 0, gain 3.0, hold_seconds 2.
module wall_follow_bump_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ir_left[7:0], ir_middle[15:8], ir_right[23:16], bump_switches[29:24],
    // now_seconds[61:30], zero fill[63:62]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive_cmd[15:0], turn_cmd[31:16], phase[33:32], zero fill[39:34]
    output logic [39:0] m_tdata
);

    wfbc_pkg::cfg_t    cfg;
    wfbc_pkg::item_t   item;
    wfbc_pkg::stage1_t s1_data;
    wfbc_pkg::stage2_t s2_data;
    wfbc_pkg::status_t status;
    logic              s1_valid, s1_ready;
    logic              s2_valid, s2_ready;

    assign item.ir_left       = s_tdata[7:0];
    assign item.ir_middle     = s_tdata[15:8];
    assign item.ir_right      = s_tdata[23:16];
    assign item.bump_switches = s_tdata[29:24];
    assign item.now_seconds   = s_tdata[61:30];

    wfbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wfbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data),
        .status    (status)
    );

    wfbc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    wfbc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .in_data  (s2_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // The phase only moves when an input transfer is taken.
    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) |=> $stable(status.phase))
        else $error("phase changed without an input transfer");

    // A pressed switch in left-wall mode always leaves the block backing.
    a_bump_backs: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !cfg.follow_side
         && (s_tdata[29:24] != wfbc_pkg::BUMP_NONE))
        |=> (status.phase == wfbc_pkg::PH_BACK) && status.stamp_valid)
        else $error("bump did not force the backing phase");

    // With every stage full and the output stalled, no transfer may enter.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s1_valid && s2_valid) |-> !s_tready)
        else $error("input accepted into a full pipeline");
`endif

endmodule

// File: rtl/core/wfbc_regs.sv
module wfbc_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output wfbc_pkg::cfg_t      cfg
);

    logic        follow_side_reg;
    logic [15:0] gain_reg;
    logic [7:0]  hold_seconds_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            follow_side_reg  <= 1'b0;
            gain_reg         <= wfbc_pkg::GAIN_RESET;
            hold_seconds_reg <= wfbc_pkg::HOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                wfbc_pkg::REG_FOLLOW_SIDE:  follow_side_reg  <= pwdata[0];
                wfbc_pkg::REG_GAIN:         gain_reg         <= pwdata[15:0];
                wfbc_pkg::REG_HOLD_SECONDS: hold_seconds_reg <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            wfbc_pkg::REG_FOLLOW_SIDE:  prdata = {31'd0, follow_side_reg};
            wfbc_pkg::REG_GAIN:         prdata = {16'd0, gain_reg};
            wfbc_pkg::REG_HOLD_SECONDS: prdata = {24'd0, hold_seconds_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.follow_side  = follow_side_reg;
    assign cfg.gain         = gain_reg;
    assign cfg.hold_seconds = hold_seconds_reg;

endmodule

// File: rtl/core/wfbc_front.sv
module wfbc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wfbc_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wfbc_pkg::item_t      item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wfbc_pkg::stage1_t    out_data,
    output wfbc_pkg::status_t    status
);

    wfbc_pkg::phase_t  phase_reg, phase_next, phase_cur;
    logic              stamp_valid_reg, stamp_valid_next, stamp_valid_cur;
    logic [31:0]       stamp_seconds_reg, stamp_seconds_next, stamp_seconds_cur;
    logic              valid_reg;
    wfbc_pkg::stage1_t stage_reg, stage_next;

    logic signed [8:0] err_left, err_mid, err_right, err_sel, err_abs;
    logic [32:0]       deadline;
    logic              expired;
    logic              accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign err_left  = $signed({1'b0, item.ir_left}) - wfbc_pkg::IR_TARGET;
    assign err_mid   = wfbc_pkg::MID_TARGET - $signed({1'b0, item.ir_middle});
    assign err_right = $signed({1'b0, item.ir_right}) - wfbc_pkg::IR_TARGET;

    always_comb
    begin
        phase_cur         = phase_reg;
        stamp_valid_cur   = stamp_valid_reg;
        stamp_seconds_cur = stamp_seconds_reg;
        // In left-wall mode a pressed switch forces backing and restamps on every tick.
        if (!cfg.follow_side && (item.bump_switches != wfbc_pkg::BUMP_NONE))
        begin
            phase_cur         = wfbc_pkg::PH_BACK;
            stamp_valid_cur   = 1'b1;
            stamp_seconds_cur = item.now_seconds;
        end

        deadline = {1'b0, stamp_seconds_cur} + {25'd0, cfg.hold_seconds};
        expired  = {1'b0, item.now_seconds} > deadline;

        phase_next         = phase_reg;
        stamp_valid_next   = stamp_valid_reg;
        stamp_seconds_next = stamp_seconds_reg;

        err_sel             = '0;
        stage_next.neg      = 1'b0;
        stage_next.div600   = 1'b0;
        stage_next.sel      = wfbc_pkg::SEL_NONE;
        stage_next.drive_k  = wfbc_pkg::Q_HALF;
        stage_next.turn_k   = wfbc_pkg::Q_ZERO;

        if (cfg.follow_side)
        begin
            err_sel        = err_right;
            stage_next.neg = err_right[8];
            stage_next.sel = wfbc_pkg::SEL_TURN;
        end
        else
        begin
            phase_next         = phase_cur;
            stamp_valid_next   = stamp_valid_cur;
            stamp_seconds_next = stamp_seconds_cur;
            unique case (phase_cur)
                wfbc_pkg::PH_BACK:
                begin
                    if (!stamp_valid_cur)
                    begin
                        stamp_valid_next   = 1'b1;
                        stamp_seconds_next = item.now_seconds;
                    end
                    else if (expired)
                    begin
                        stamp_valid_next = 1'b0;
                        phase_next       = wfbc_pkg::PH_FWD;
                    end
                    stage_next.drive_k = wfbc_pkg::Q_BACK_DRIVE;
                    stage_next.turn_k  = wfbc_pkg::Q_BACK_TURN;
                end
                wfbc_pkg::PH_FWD:
                begin
                    if (!stamp_valid_cur)
                    begin
                        stamp_valid_next   = 1'b1;
                        stamp_seconds_next = item.now_seconds;
                    end
                    else if (expired)
                    begin
                        stamp_valid_next = 1'b0;
                        phase_next       = wfbc_pkg::PH_WALL;
                    end
                end
                wfbc_pkg::PH_WALL:
                begin
                    if (err_mid < wfbc_pkg::MID_THRESHOLD)
                    begin
                        phase_next = wfbc_pkg::PH_OBST;
                    end
                    // The turn is the negated quotient, so the sign flips.
                    err_sel        = err_left;
                    stage_next.neg = !err_left[8];
                    stage_next.sel = wfbc_pkg::SEL_TURN;
                end
                wfbc_pkg::PH_OBST:
                begin
                    if (err_mid >= wfbc_pkg::MID_THRESHOLD)
                    begin
                        phase_next = wfbc_pkg::PH_WALL;
                    end
                    err_sel           = err_mid;
                    stage_next.neg    = err_mid[8];
                    stage_next.div600 = 1'b1;
                    stage_next.sel    = wfbc_pkg::SEL_DRIVE;
                    stage_next.turn_k = wfbc_pkg::Q_OBST_TURN;
                end
                default:
                begin
                    phase_next = wfbc_pkg::PH_WALL;
                end
            endcase
        end

        err_abs          = err_sel[8] ? -err_sel : err_sel;
        stage_next.prod  = {8'd0, cfg.gain} * {16'd0, err_abs[7:0]};
        stage_next.phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= wfbc_pkg::PH_WALL;
            stamp_valid_reg   <= 1'b0;
            stamp_seconds_reg <= 32'd0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                stamp_valid_reg   <= stamp_valid_next;
                stamp_seconds_reg <= stamp_seconds_next;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid          = valid_reg;
    assign out_data           = stage_reg;
    assign status.phase       = phase_reg;
    assign status.stamp_valid = stamp_valid_reg;

endmodule

// File: rtl/core/wfbc_scale.sv
module wfbc_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wfbc_pkg::stage1_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wfbc_pkg::stage2_t    out_data
);

    logic                            valid_reg;
    wfbc_pkg::stage2_t               stage_reg, stage_next;
    logic [wfbc_pkg::RECIP_W-1:0]    recip;
    logic [wfbc_pkg::FULL_W-1:0]     full;

    assign in_ready = !valid_reg || out_ready;

    // Truncating division of the magnitude by 100 or 600.
    assign recip = in_data.div600 ? wfbc_pkg::RECIP_600 : wfbc_pkg::RECIP_100;
    assign full  = {{wfbc_pkg::RECIP_W{1'b0}}, in_data.prod}
                 * {{wfbc_pkg::PROD_W{1'b0}}, recip};

    always_comb
    begin
        if (in_data.div600)
        begin
            stage_next.quot = {{(wfbc_pkg::Q_W - wfbc_pkg::Q600_W){1'b0}},
                               full[wfbc_pkg::SHIFT_600 +: wfbc_pkg::Q600_W]};
        end
        else
        begin
            stage_next.quot = full[wfbc_pkg::SHIFT_100 +: wfbc_pkg::Q_W];
        end
        stage_next.neg     = in_data.neg;
        stage_next.sel     = in_data.sel;
        stage_next.drive_k = in_data.drive_k;
        stage_next.turn_k  = in_data.turn_k;
        stage_next.phase   = in_data.phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

endmodule

// File: rtl/core/wfbc_out.sv
module wfbc_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wfbc_pkg::stage2_t    in_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata
);

    logic               valid_reg;
    logic signed [15:0] drive_reg, drive_next;
    logic signed [15:0] turn_reg, turn_next;
    logic [1:0]         phase_reg;
    logic signed [17:0] signed_quot;
    logic signed [15:0] sat_quot;

    assign in_ready = !valid_reg || m_tready;

    assign signed_quot = in_data.neg ? -$signed({1'b0, in_data.quot})
                                     : $signed({1'b0, in_data.quot});

    always_comb
    begin
        if (signed_quot > 18'sd32767)
        begin
            sat_quot = 16'sd32767;
        end
        else if (signed_quot < -18'sd32768)
        begin
            sat_quot = -16'sd32768;
        end
        else
        begin
            sat_quot = signed_quot[15:0];
        end

        drive_next = in_data.drive_k;
        turn_next  = in_data.turn_k;
        case (in_data.sel)
            wfbc_pkg::SEL_DRIVE: drive_next = sat_quot;
            wfbc_pkg::SEL_TURN:  turn_next  = sat_quot;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg <= drive_next;
            turn_reg  <= turn_next;
            phase_reg <= in_data.phase;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, phase_reg, turn_reg, drive_reg};

endmodule

// File: bench/tb_wall_follow_bump_controller_unit.sv
module tb_wall_follow_bump_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wfbc_pkg::*;

    // Keeps its own copy of the controller state and registers, works out
    // the command for every accepted tick and checks results in order.
    class cmd_scoreboard;
        typedef struct packed {
            logic [15:0] drive;
            logic [15:0] turn;
            phase_t      phase;
        } cmd_t;

        logic        follow_side;
        logic [15:0] gain;
        logic [7:0]  hold_seconds;
        phase_t      phase_now;
        logic        stamp_valid;
        logic [31:0] stamp_seconds;
        cmd_t        pending_cmds[$];
        int unsigned mismatches;

        function new();
            follow_side   = 1'b0;
            gain          = GAIN_RESET;
            hold_seconds  = HOLD_RESET;
            phase_now     = PH_WALL;
            stamp_valid   = 1'b0;
            stamp_seconds = '0;
            mismatches    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FOLLOW_SIDE:  follow_side = value[0];
                REG_GAIN:         gain = value[15:0];
                REG_HOLD_SECONDS: hold_seconds = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] sat16(longint v);
            if (v > 32767)
                return 16'h7FFF;
            if (v < -32768)
                return 16'h8000;
            return v[15:0];
        endfunction

        // The deadline is formed in 33 bits, so it never wraps.
        function void timed_step(logic [31:0] now, phase_t next_phase);
            logic [32:0] deadline;
            deadline = {1'b0, stamp_seconds} + 33'(hold_seconds);
            if (!stamp_valid) begin
                stamp_seconds = now;
                stamp_valid   = 1'b1;
            end
            else if ({1'b0, now} > deadline) begin
                stamp_valid = 1'b0;
                phase_now   = next_phase;
            end
        endfunction

        function void note_tick(logic [7:0] ir_l, logic [7:0] ir_m, logic [7:0] ir_r,
                                logic [5:0] sw, logic [31:0] now);
            longint g;
            longint err_l;
            longint err_m;
            longint drive;
            longint turn;
            cmd_t   c;
            g = longint'(gain);
            if (!follow_side) begin
                err_l = longint'(ir_l) - longint'(IR_TARGET);
                err_m = longint'(MID_TARGET) - longint'(ir_m);
                if (sw != BUMP_NONE) begin
                    phase_now     = PH_BACK;
                    stamp_seconds = now;
                    stamp_valid   = 1'b1;
                end
                case (phase_now)
                    PH_BACK: begin
                        timed_step(now, PH_FWD);
                        drive = longint'(Q_BACK_DRIVE);
                        turn  = longint'(Q_BACK_TURN);
                    end
                    PH_FWD: begin
                        timed_step(now, PH_WALL);
                        drive = longint'(Q_HALF);
                        turn  = longint'(Q_ZERO);
                    end
                    PH_WALL: begin
                        if (err_m < longint'(MID_THRESHOLD))
                            phase_now = PH_OBST;
                        drive = longint'(Q_HALF);
                        turn  = -((g * err_l) / 100);
                    end
                    default: begin
                        if (err_m >= longint'(MID_THRESHOLD))
                            phase_now = PH_WALL;
                        drive = (g * err_m) / 600;
                        turn  = longint'(Q_OBST_TURN);
                    end
                endcase
            end
            else begin
                drive = longint'(Q_HALF);
                turn  = (g * (longint'(ir_r) - longint'(IR_TARGET))) / 100;
            end
            c.drive = sat16(drive);
            c.turn  = sat16(turn);
            c.phase = phase_now;
            pending_cmds.push_back(c);
        endfunction

        function void check_cmd(logic [39:0] data);
            cmd_t c;
            if (pending_cmds.size() == 0) begin
                $error("result transfer with no command pending: %h", data);
                mismatches++;
                return;
            end
            c = pending_cmds.pop_front();
            if (data[15:0] !== c.drive) begin
                $error("drive_cmd mismatch: expected %0d, actual %0d",
                       $signed(c.drive), $signed(data[15:0]));
                mismatches++;
            end
            if (data[31:16] !== c.turn) begin
                $error("turn_cmd mismatch: expected %0d, actual %0d",
                       $signed(c.turn), $signed(data[31:16]));
                mismatches++;
            end
            if (data[33:32] !== c.phase) begin
                $error("phase mismatch: expected %0d, actual %0d", c.phase, data[33:32]);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // ir_left[7:0], ir_middle[15:8], ir_right[23:16], bump_switches[29:24],
    // now_seconds[61:30], zero fill[63:62]
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // drive_cmd[15:0], turn_cmd[31:16], phase[33:32], zero fill[39:34]
    logic [39:0] m_tdata;

    cmd_scoreboard sb;
    int unsigned   send_idle_pct = 35;
    int unsigned   recv_idle_pct = 58;
    bit            stall_request = 1'b0;
    logic [31:0]   now_clock = '0;

    // Register settings per random phase: side, gain, hold.
    bit          set_side[9] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [15:0] set_gain[9] = '{16'd12288, 16'd0, 16'd65535, 16'd65535, 16'd4096,
                                 16'd0, 16'd30000, 16'd12288, 16'd50000};
    logic [7:0]  set_hold[9] = '{8'd2, 8'd0, 8'd1, 8'd3, 8'd255, 8'd2, 8'd3, 8'd0, 8'd1};

    wall_follow_bump_controller_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_wall_follow_bump_controller_unit NOT OK");
        $finish;
    end

    // Transfers are sampled at the edge where they happen.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_tick(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[29:24],
                         s_tdata[61:30]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_cmd(m_tdata);
    end

    // Receiver side: random back-pressure, or a long hold-off on request.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_request) begin
                stall_request = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic send_tick(logic [7:0] ir_l, logic [7:0] ir_m, logic [7:0] ir_r,
                             logic [5:0] sw, logic [31:0] now);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, now, sw, ir_r, ir_m, ir_l};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops offering ticks and waits until every command has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Time mostly creeps forward so the timed phases run out; bumps are rare.
    task automatic send_random_tick();
        int unsigned pick;
        logic [5:0]  sw;
        logic [7:0]  mid;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            now_clock = $urandom();
        else if (pick < 15)
            now_clock += $urandom_range(3, 300);
        else
            now_clock += $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        if (pick < 6)
            sw = 6'($urandom_range(0, 62));
        else if (pick < 8)
            sw = 6'($urandom());
        else
            sw = BUMP_NONE;
        mid = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 30)) : 8'($urandom());
        send_tick(8'($urandom()), mid, 8'($urandom()), sw, now_clock);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Left wall at reset settings: follow, obstacle turn and its threshold.
        send_tick(8'd255, 8'd0, 8'd0, BUMP_NONE, 32'd100);
        send_tick(8'd0, 8'd17, 8'd255, BUMP_NONE, 32'd100);
        send_tick(8'd100, 8'd18, 8'd0, BUMP_NONE, 32'd100);
        send_tick(8'd0, 8'd255, 8'd0, BUMP_NONE, 32'd101);
        send_tick(8'd255, 8'd0, 8'd0, BUMP_NONE, 32'd101);
        // A bump near the top of the time range holds across the wrap.
        send_tick(8'd100, 8'd0, 8'd0, 6'h00, 32'hFFFF_FFFE);
        send_tick(8'd100, 8'd0, 8'd0, 6'h3E, 32'hFFFF_FFFF);
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'hFFFF_FFFF);
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'h0000_0000);
        for (int k = 0; k < 6; k++)
            send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE ^ (6'd1 << k), 32'd10);
        // Backing ends strictly after the hold, then the timed forward run.
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'd12);
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'd13);
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'd13);
        send_tick(8'd100, 8'd0, 8'd0, BUMP_NONE, 32'd17);
        wait_idle();

        // Right wall with full gain saturates both ways and ignores bumps.
        apb_write(REG_FOLLOW_SIDE, 32'd1);
        apb_write(REG_GAIN, 32'd65535);
        apb_write(REG_HOLD_SECONDS, 32'd0);
        send_tick(8'd0, 8'd0, 8'd255, 6'h00, 32'd5);
        send_tick(8'd0, 8'd0, 8'd0, BUMP_NONE, 32'd6);
        send_tick(8'd0, 8'd0, 8'd100, BUMP_NONE, 32'd7);
        now_clock = 32'd20;

        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            apb_write(REG_FOLLOW_SIDE, 32'(set_side[p]));
            apb_write(REG_GAIN, 32'(set_gain[p]));
            apb_write(REG_HOLD_SECONDS, 32'(set_hold[p]));
            if (p < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 58;
            end
            else if (p < 6) begin
                send_idle_pct = 58;
                recv_idle_pct = 35;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 200; k++)
            begin
                if (p == 1 && k == 100)
                    wait_idle();
                if (p == 6 && k == 20)
                    stall_request = 1'b1;
                send_random_tick();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_cmds.size() == 0)
            $display("tb_wall_follow_bump_controller_unit OK");
        else
            $display("tb_wall_follow_bump_controller_unit NOT OK");
        $finish;
    end

endmodule
